// ----- src/bmhpq_pkg.sv -----
// bmhpq_pkg: shared types and codes for the binary min-heap priority queue
// no dependencies; used by the top level and its checker
`default_nettype none

package bmhpq_pkg;

   localparam int VID_BITS  = 11;
   localparam int KEY_IN_BITS = 31;

   // operation codes
   localparam logic [1:0] FUNC_LOAD     = 2'd0;
   localparam logic [1:0] FUNC_BUILD    = 2'd1;
   localparam logic [1:0] FUNC_EXTRACT  = 2'd2;
   localparam logic [1:0] FUNC_DECREASE = 2'd3;

   // status codes
   localparam logic [1:0] ST_DONE     = 2'd0;
   localparam logic [1:0] ST_EMPTY    = 2'd1;
   localparam logic [1:0] ST_NOTFOUND = 2'd2;
   localparam logic [1:0] ST_FULL     = 2'd3;

   typedef struct packed {
      logic [1:0]             func;
      logic [VID_BITS-1:0]    vertex_id;
      logic [KEY_IN_BITS-1:0] key;
   } req_type;

   typedef struct packed {
      logic [VID_BITS-1:0] min_vertex;
      logic [1:0]          status;
   } rsp_type;

endpackage

`default_nettype wire

// ----- src/bmhpq_ram.sv -----
// bmhpq_ram: single write port, single registered read port heap store
// no dependencies
`default_nettype none

module bmhpq_ram #(
   parameter int DEPTH = 1024,
   parameter int WIDTH = 42
) (
   input  wire logic                     clock,
   input  wire logic                     wr_en,
   input  wire logic [$clog2(DEPTH)-1:0] wr_addr,
   input  wire logic [WIDTH-1:0]         wr_data,
   input  wire logic [$clog2(DEPTH)-1:0] rd_addr,
   output logic      [WIDTH-1:0]         rd_data
);

   logic [WIDTH-1:0] mem [DEPTH];

   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem[wr_addr] <= wr_data;
      end
      rd_data <= mem[rd_addr];
   end

endmodule

`default_nettype wire

// ----- src/binary_min_heap_priority_queue.sv -----
// binary min-heap of (key, vertex) pairs with load, build, extract-min and decrease-key
// depends on bmhpq_pkg and bmhpq_ram
// load writes the next free slot; extract sifts the last entry down from the root; decrease-key
// scans the slots in order, then sifts up; build runs one sift-down per internal node
// one transaction at a time; the single read port of the heap ram sets the pace
// reset clears the count and control only; heap ram contents are not cleared
`default_nettype none

module binary_min_heap_priority_queue #(
   parameter int CAPACITY = 1024,
   parameter int KEY_BITS = 31
) (
   input  wire logic               clock,
   input  wire logic               reset,
   input  wire logic               req_valid,
   output logic                    req_ready,
   input  wire bmhpq_pkg::req_type req_data,
   output logic                    rsp_valid,
   input  wire logic               rsp_ready,
   output bmhpq_pkg::rsp_type      rsp_data
);

   // slot numbers run 1..CAPACITY; ram address is slot - 1
   localparam int VW = $clog2(CAPACITY + 1);
   localparam int AW = $clog2(CAPACITY);
   localparam int CW = (VW > bmhpq_pkg::VID_BITS) ? VW : bmhpq_pkg::VID_BITS;
   localparam int EW = KEY_BITS + VW;

   localparam logic [VW-1:0] ONE = VW'(1);
   localparam logic [VW-1:0] CAP = VW'(CAPACITY);

   // sequencer states
   localparam logic [3:0] S_IDLE     = 4'd0;
   localparam logic [3:0] S_EX_RN    = 4'd1;
   localparam logic [3:0] S_EX_MV    = 4'd2;
   localparam logic [3:0] S_BD_MV    = 4'd3;
   localparam logic [3:0] S_SD_START = 4'd4;
   localparam logic [3:0] S_SD_L     = 4'd5;
   localparam logic [3:0] S_SD_R     = 4'd6;
   localparam logic [3:0] S_SD_CMP   = 4'd7;
   localparam logic [3:0] S_DK_SCAN  = 4'd8;
   localparam logic [3:0] S_SU_START = 4'd9;
   localparam logic [3:0] S_SU_CMP   = 4'd10;
   localparam logic [3:0] S_FIN      = 4'd11;

   logic [3:0]    state_ff, state_in;
   logic [VW-1:0] count_ff, count_in;     // live entries
   logic [VW-1:0] pos_ff, pos_in;         // hole being sifted
   logic [VW-1:0] idx_ff, idx_in;         // build node or scan slot
   logic [VW-1:0] cpos_ff, cpos_in;       // chosen child slot
   logic [EW-1:0] child_ff, child_in;     // chosen child entry
   logic [EW-1:0] move_ff, move_in;       // entry travelling through the heap
   logic          build_ff, build_in;     // sift-down belongs to a build
   logic [KEY_BITS-1:0] key_ff, key_in;
   logic [bmhpq_pkg::VID_BITS-1:0] vid_ff, vid_in;
   logic [bmhpq_pkg::VID_BITS-1:0] minv_ff, minv_in;
   logic [1:0]    status_ff, status_in;
   logic          rsp_valid_ff;
   bmhpq_pkg::rsp_type rsp_ff;

   logic          wr_en;
   logic [VW-1:0] wr_slot, rd_slot;
   logic [EW-1:0] wr_data, rd_data;
   logic          fin_take;

   logic [KEY_BITS-1:0] req_key;
   logic [KEY_BITS-1:0] rd_key, move_key, child_key;
   logic [VW-1:0]       rd_vert;
   logic [AW-1:0]       slot_m1_wr, slot_m1_rd;

   assign req_key   = KEY_BITS'(req_data.key);
   assign rd_key    = rd_data[EW-1:VW];
   assign rd_vert   = rd_data[VW-1:0];
   assign move_key  = move_ff[EW-1:VW];
   assign child_key = child_ff[EW-1:VW];

   assign slot_m1_wr = AW'(wr_slot - ONE);
   assign slot_m1_rd = AW'(rd_slot - ONE);

   bmhpq_ram #(
      .DEPTH(CAPACITY),
      .WIDTH(EW)
   ) u_ram (
      .clock  (clock),
      .wr_en  (wr_en),
      .wr_addr(slot_m1_wr),
      .wr_data(wr_data),
      .rd_addr(slot_m1_rd),
      .rd_data(rd_data)
   );

   assign req_ready = (state_ff == S_IDLE);
   assign fin_take  = (state_ff == S_FIN) && (!rsp_valid_ff || rsp_ready);

   always_comb begin
      state_in  = state_ff;
      count_in  = count_ff;
      pos_in    = pos_ff;
      idx_in    = idx_ff;
      cpos_in   = cpos_ff;
      child_in  = child_ff;
      move_in   = move_ff;
      build_in  = build_ff;
      key_in    = key_ff;
      vid_in    = vid_ff;
      minv_in   = minv_ff;
      status_in = status_ff;
      wr_en     = 1'b0;
      wr_slot   = pos_ff;
      wr_data   = move_ff;
      rd_slot   = pos_ff;

      case (state_ff)
         S_IDLE: begin
            if (req_valid) begin
               key_in    = req_key;
               vid_in    = req_data.vertex_id;
               minv_in   = '0;
               status_in = bmhpq_pkg::ST_DONE;
               state_in  = S_FIN;
               case (req_data.func)
                  bmhpq_pkg::FUNC_LOAD: begin
                     if (count_ff == CAP) begin
                        status_in = bmhpq_pkg::ST_FULL;
                     end else begin
                        wr_en    = 1'b1;
                        wr_slot  = count_ff + ONE;
                        wr_data  = {req_key, count_ff + ONE};
                        count_in = count_ff + ONE;
                     end
                  end
                  bmhpq_pkg::FUNC_BUILD: begin
                     if ((count_ff >> 1) != '0) begin
                        idx_in   = count_ff >> 1;
                        rd_slot  = count_ff >> 1;
                        build_in = 1'b1;
                        state_in = S_BD_MV;
                     end
                  end
                  bmhpq_pkg::FUNC_EXTRACT: begin
                     if (count_ff == '0) begin
                        status_in = bmhpq_pkg::ST_EMPTY;
                     end else begin
                        rd_slot  = ONE;
                        build_in = 1'b0;
                        state_in = S_EX_RN;
                     end
                  end
                  default: begin
                     status_in = bmhpq_pkg::ST_NOTFOUND;
                     if (count_ff != '0) begin
                        rd_slot  = ONE;
                        idx_in   = ONE;
                        state_in = S_DK_SCAN;
                     end
                  end
               endcase
            end
         end
         S_EX_RN: begin
            // root arrives; fetch last entry
            minv_in  = bmhpq_pkg::VID_BITS'(rd_vert);
            rd_slot  = count_ff;
            state_in = S_EX_MV;
         end
         S_EX_MV: begin
            move_in  = rd_data;
            count_in = count_ff - ONE;
            pos_in   = ONE;
            state_in = (count_ff == ONE) ? S_FIN : S_SD_START;
         end
         S_BD_MV: begin
            move_in  = rd_data;
            pos_in   = idx_ff;
            state_in = S_SD_START;
         end
         S_SD_START: begin
            if (pos_ff > (count_ff >> 1)) begin
               // leaf reached: drop the travelling entry into the hole
               wr_en = 1'b1;
               if (build_ff && (idx_ff > ONE)) begin
                  idx_in   = idx_ff - ONE;
                  rd_slot  = idx_ff - ONE;
                  state_in = S_BD_MV;
               end else begin
                  state_in = S_FIN;
               end
            end else begin
               rd_slot  = pos_ff << 1;
               cpos_in  = pos_ff << 1;
               state_in = S_SD_L;
            end
         end
         S_SD_L: begin
            child_in = rd_data;
            if (cpos_ff < count_ff) begin
               rd_slot  = cpos_ff + ONE;
               state_in = S_SD_R;
            end else begin
               state_in = S_SD_CMP;
            end
         end
         S_SD_R: begin
            // right child wins only when strictly smaller
            if (child_key > rd_key) begin
               child_in = rd_data;
               cpos_in  = cpos_ff + ONE;
            end
            state_in = S_SD_CMP;
         end
         S_SD_CMP: begin
            wr_en = 1'b1;
            if (move_key > child_key) begin
               wr_data  = child_ff;
               pos_in   = cpos_ff;
               state_in = S_SD_START;
            end else if (build_ff && (idx_ff > ONE)) begin
               idx_in   = idx_ff - ONE;
               rd_slot  = idx_ff - ONE;
               state_in = S_BD_MV;
            end else begin
               state_in = S_FIN;
            end
         end
         S_DK_SCAN: begin
            // one slot per cycle; next read issued speculatively
            if (CW'(rd_vert) == CW'(vid_ff)) begin
               move_in   = {key_ff, rd_vert};
               pos_in    = idx_ff;
               status_in = bmhpq_pkg::ST_DONE;
               state_in  = S_SU_START;
            end else if (idx_ff == count_ff) begin
               state_in = S_FIN;
            end else begin
               idx_in  = idx_ff + ONE;
               rd_slot = idx_ff + ONE;
            end
         end
         S_SU_START: begin
            if (pos_ff == ONE) begin
               wr_en    = 1'b1;
               state_in = S_FIN;
            end else begin
               rd_slot  = pos_ff >> 1;
               state_in = S_SU_CMP;
            end
         end
         S_SU_CMP: begin
            wr_en = 1'b1;
            if (move_key < rd_key) begin
               wr_data  = rd_data;
               pos_in   = pos_ff >> 1;
               state_in = S_SU_START;
            end else begin
               state_in = S_FIN;
            end
         end
         S_FIN: begin
            if (fin_take) begin
               state_in = S_IDLE;
            end
         end
         default: begin
            state_in = S_IDLE;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= S_IDLE;
         count_ff <= '0;
         build_ff <= 1'b0;
      end else begin
         state_ff <= state_in;
         count_ff <= count_in;
         build_ff <= build_in;
      end
   end

   // datapath registers, no reset needed
   always_ff @(posedge clock) begin
      pos_ff    <= pos_in;
      idx_ff    <= idx_in;
      cpos_ff   <= cpos_in;
      child_ff  <= child_in;
      move_ff   <= move_in;
      key_ff    <= key_in;
      vid_ff    <= vid_in;
      minv_ff   <= minv_in;
      status_ff <= status_in;
   end

   // output register parts the sequencer from the result side
   always_ff @(posedge clock) begin
      if (reset) begin
         rsp_valid_ff <= 1'b0;
      end else if (fin_take) begin
         rsp_valid_ff <= 1'b1;
      end else if (rsp_ready) begin
         rsp_valid_ff <= 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (fin_take) begin
         rsp_ff.min_vertex <= minv_ff;
         rsp_ff.status     <= status_ff;
      end
   end

   assign rsp_valid = rsp_valid_ff;
   assign rsp_data  = rsp_ff;

endmodule

`default_nettype wire

// ----- src/bmhpq_check.sv -----
// bmhpq_check: port-level checker for the heap priority queue, with its bind
// depends on bmhpq_pkg
`default_nettype none

module bmhpq_check (
   input wire logic               clock,
   input wire logic               reset,
   input wire logic               req_valid,
   input wire logic               req_ready,
   input wire bmhpq_pkg::req_type req_data,
   input wire logic               rsp_valid,
   input wire logic               rsp_ready,
   input wire bmhpq_pkg::rsp_type rsp_data
);

   // transactions accepted but not yet answered
   logic [1:0] pend_ff, pend_in;

   always_comb begin
      pend_in = pend_ff;
      if ((req_valid && req_ready) && !(rsp_valid && rsp_ready)) begin
         pend_in = pend_ff + 2'd1;
      end else if (!(req_valid && req_ready) && (rsp_valid && rsp_ready)) begin
         pend_in = pend_ff - 2'd1;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         pend_ff <= '0;
      end else begin
         pend_ff <= pend_in;
      end
   end

   a_req_hold: assert property (@(posedge clock) disable iff (reset)
      req_valid && !req_ready |=> req_valid && $stable(req_data))
      else $error("request changed while waiting");

   a_rsp_hold: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && !rsp_ready |=> rsp_valid && $stable(rsp_data))
      else $error("result changed while stalled");

   a_no_spurious: assert property (@(posedge clock) disable iff (reset)
      rsp_valid |-> pend_ff != 2'd0)
      else $error("result without a transaction");

   a_busy_full: assert property (@(posedge clock) disable iff (reset)
      pend_ff == 2'd2 |-> !req_ready)
      else $error("accepted a third transaction");

   a_vertex_zero: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && rsp_data.status != bmhpq_pkg::ST_DONE |-> rsp_data.min_vertex == '0)
      else $error("failed operation returned a vertex");

endmodule

bind binary_min_heap_priority_queue bmhpq_check u_bmhpq_check (
   .clock    (clock),
   .reset    (reset),
   .req_valid(req_valid),
   .req_ready(req_ready),
   .req_data (req_data),
   .rsp_valid(rsp_valid),
   .rsp_ready(rsp_ready),
   .rsp_data (rsp_data)
);

`default_nettype wire

// ----- sim/binary_min_heap_priority_queue_tb.sv -----
// binary_min_heap_priority_queue_tb: self-checking bench for the min-heap priority queue
// a local heap predictor is checked against each response, with random idling and stalls
// depends on bmhpq_pkg and binary_min_heap_priority_queue
`default_nettype none

module binary_min_heap_priority_queue_tb;
   timeunit 1ns;
   timeprecision 1ps;

   localparam int HEAP_DEPTH = 1024;
   // a build over a full heap is the slowest single transaction
   localparam int STALL_LIMIT = 200000;
   localparam int TAIL_CYCLES = 50;

   logic               clock;
   logic               reset;
   logic               req_valid;
   logic               req_ready;
   bmhpq_pkg::req_type req_data;
   logic               rsp_valid;
   logic               rsp_ready;
   bmhpq_pkg::rsp_type rsp_data;

   binary_min_heap_priority_queue #(
      .CAPACITY(HEAP_DEPTH),
      .KEY_BITS(bmhpq_pkg::KEY_IN_BITS)
   ) dut (
      .clock    (clock),
      .reset    (reset),
      .req_valid(req_valid),
      .req_ready(req_ready),
      .req_data (req_data),
      .rsp_valid(rsp_valid),
      .rsp_ready(rsp_ready),
      .rsp_data (rsp_data)
   );

   initial begin
      clock = 1'b0;
      forever #1 clock = ~clock;
   end

   // predicted heap, slots 1..heap_count are live, slot 1 is the root
   logic [bmhpq_pkg::KEY_IN_BITS-1:0] heap_key [1:HEAP_DEPTH];
   logic [bmhpq_pkg::VID_BITS-1:0]    heap_vid [1:HEAP_DEPTH];
   int unsigned                       heap_count;

   bmhpq_pkg::rsp_type pending_rsp[$];

   int error_count;
   int sent_count;
   int checked_count;
   int full_hits;
   int empty_hits;
   int missing_hits;
   bit no_idle;           // when set neither side inserts gaps
   int long_hold;         // receiver hold-off request, counted down by the receiver
   int rsp_stall;         // per-response stall drawn after each accepted response
   bit busy_seen;
   int quiet_cycles;

   // ---------------------------------------------------------------------------
   // heap predictor
   // ---------------------------------------------------------------------------
   function automatic void slot_swap(int unsigned a, int unsigned b);
      logic [bmhpq_pkg::KEY_IN_BITS-1:0] k;
      logic [bmhpq_pkg::VID_BITS-1:0]    v;
      k = heap_key[a];
      v = heap_vid[a];
      heap_key[a] = heap_key[b];
      heap_vid[a] = heap_vid[b];
      heap_key[b] = k;
      heap_vid[b] = v;
   endfunction

   function automatic void push_down(int unsigned pos, int unsigned n);
      int unsigned c;
      while (pos >= 1 && pos <= n / 2) begin
         c = 2 * pos;
         // right child wins only when strictly smaller
         if (c < n && heap_key[c] > heap_key[c+1])
            c++;
         if (heap_key[pos] > heap_key[c]) begin
            slot_swap(pos, c);
            pos = c;
         end else begin
            break;
         end
      end
   endfunction

   function automatic bmhpq_pkg::rsp_type heap_apply(bmhpq_pkg::req_type r);
      bmhpq_pkg::rsp_type res;
      int unsigned        n;
      int unsigned        i;
      res = '0;
      res.status = bmhpq_pkg::ST_DONE;
      n = heap_count;
      case (r.func)
         bmhpq_pkg::FUNC_LOAD: begin
            if (n >= HEAP_DEPTH) begin
               res.status = bmhpq_pkg::ST_FULL;
               full_hits++;
            end else begin
               n++;
               heap_key[n] = r.key;
               heap_vid[n] = bmhpq_pkg::VID_BITS'(n);
            end
         end
         bmhpq_pkg::FUNC_BUILD: begin
            for (i = n / 2; i >= 1; i--)
               push_down(i, n);
         end
         bmhpq_pkg::FUNC_EXTRACT: begin
            if (n == 0) begin
               res.status = bmhpq_pkg::ST_EMPTY;
               empty_hits++;
            end else begin
               res.min_vertex = heap_vid[1];
               if (n > 1) begin
                  slot_swap(1, n);
                  n--;
                  push_down(1, n);
               end else begin
                  n--;
               end
            end
         end
         default: begin
            // decrease-key: first matching slot, sift up only
            res.status = bmhpq_pkg::ST_NOTFOUND;
            for (i = 1; i <= n; i++) begin
               if (heap_vid[i] == r.vertex_id) begin
                  heap_key[i] = r.key;
                  while (i > 1 && heap_key[i] < heap_key[i/2]) begin
                     slot_swap(i, i / 2);
                     i = i / 2;
                  end
                  res.status = bmhpq_pkg::ST_DONE;
                  break;
               end
            end
            if (res.status == bmhpq_pkg::ST_NOTFOUND)
               missing_hits++;
         end
      endcase
      heap_count = n;
      return res;
   endfunction

   // ---------------------------------------------------------------------------
   // sender: called at a rising edge, returns at the edge that accepts the transaction
   // ---------------------------------------------------------------------------
   task automatic send_txn(logic [1:0] func, logic [bmhpq_pkg::VID_BITS-1:0] vid,
                           logic [bmhpq_pkg::KEY_IN_BITS-1:0] key);
      int                 gap;
      bmhpq_pkg::req_type r;
      r.func = func;
      r.vertex_id = vid;
      r.key = key;
      gap = no_idle ? 0 : $urandom_range(0, 3);
      if (gap > 0) begin
         req_valid <= 1'b0;
         repeat (gap) @(posedge clock);
      end
      req_valid <= 1'b1;
      req_data <= r;
      do @(negedge clock); while (!req_ready);
      @(posedge clock);
      pending_rsp.push_back(heap_apply(r));
      sent_count++;
   endtask

   // sender pause until every expected response is back
   task automatic wait_drained();
      req_valid <= 1'b0;
      wait (pending_rsp.size() == 0);
      @(posedge clock);
   endtask

   function automatic logic [bmhpq_pkg::KEY_IN_BITS-1:0] rand_key();
      // narrow keys now and then so that ties are common
      if ($urandom_range(0, 3) == 0)
         return bmhpq_pkg::KEY_IN_BITS'($urandom_range(0, 7));
      return bmhpq_pkg::KEY_IN_BITS'($urandom);
   endfunction

   // ---------------------------------------------------------------------------
   // response checker and receiver
   // ---------------------------------------------------------------------------
   task automatic report_mismatch(string what, int got, int want);
      $display("mismatch on response %0d: %s got %0d expected %0d",
               checked_count, what, got, want);
      error_count++;
   endtask

   always @(negedge clock) begin
      busy_seen = (req_valid && req_ready) || (rsp_valid && rsp_ready);
      if (rsp_valid && rsp_ready) begin
         if (pending_rsp.size() == 0) begin
            report_mismatch("unexpected transaction, status", rsp_data.status, -1);
         end else begin
            if (rsp_data.min_vertex !== pending_rsp[0].min_vertex)
               report_mismatch("min_vertex", rsp_data.min_vertex,
                               pending_rsp[0].min_vertex);
            if (rsp_data.status !== pending_rsp[0].status)
               report_mismatch("status", rsp_data.status, pending_rsp[0].status);
            void'(pending_rsp.pop_front());
         end
         checked_count++;
         rsp_stall = no_idle ? 0 : $urandom_range(0, 3);
      end
   end

   always @(posedge clock) begin
      if (reset) begin
         rsp_ready <= 1'b0;
      end else if (long_hold > 0) begin
         rsp_ready <= 1'b0;
         long_hold--;
      end else if (rsp_stall > 0) begin
         rsp_ready <= 1'b0;
         rsp_stall--;
      end else begin
         rsp_ready <= 1'b1;
      end
   end

   // watchdog on cycles with no transaction on either side
   always @(posedge clock) begin
      if (busy_seen || reset)
         quiet_cycles <= 0;
      else
         quiet_cycles <= quiet_cycles + 1;
      if (quiet_cycles > STALL_LIMIT) begin
         $display("*** FAILED ***");
         $finish;
      end
   end

   // ---------------------------------------------------------------------------
   // tests
   // ---------------------------------------------------------------------------
   task automatic empty_heap_test();
      send_txn(bmhpq_pkg::FUNC_EXTRACT, '0, '0);
      send_txn(bmhpq_pkg::FUNC_DECREASE, bmhpq_pkg::VID_BITS'(1), '0);
      send_txn(bmhpq_pkg::FUNC_BUILD, '1, '1);
      send_txn(bmhpq_pkg::FUNC_EXTRACT, '1, '1);
   endtask

   task automatic directed_ops_test();
      // extreme keys and equal keys, then build, decreases and drain
      send_txn(bmhpq_pkg::FUNC_LOAD, '1, '1);
      send_txn(bmhpq_pkg::FUNC_LOAD, '0, '0);
      send_txn(bmhpq_pkg::FUNC_LOAD, '0, bmhpq_pkg::KEY_IN_BITS'(5));
      send_txn(bmhpq_pkg::FUNC_LOAD, '0, bmhpq_pkg::KEY_IN_BITS'(5));
      send_txn(bmhpq_pkg::FUNC_LOAD, '0, bmhpq_pkg::KEY_IN_BITS'(5));
      send_txn(bmhpq_pkg::FUNC_BUILD, '0, '0);
      // larger key on the root: written, no sift down
      send_txn(bmhpq_pkg::FUNC_DECREASE, bmhpq_pkg::VID_BITS'(2), '1);
      send_txn(bmhpq_pkg::FUNC_DECREASE, bmhpq_pkg::VID_BITS'(5), '0);
      send_txn(bmhpq_pkg::FUNC_DECREASE, '1, bmhpq_pkg::KEY_IN_BITS'(3));
      send_txn(bmhpq_pkg::FUNC_DECREASE, bmhpq_pkg::VID_BITS'(1024),
               bmhpq_pkg::KEY_IN_BITS'(3));
      repeat (6) send_txn(bmhpq_pkg::FUNC_EXTRACT, '0, '0);
      wait_drained();
   endtask

   task automatic back_pressure_test();
      int i;
      // receiver holds off while the sender keeps offering
      long_hold = 300;
      for (i = 0; i < 8; i++)
         send_txn(bmhpq_pkg::FUNC_LOAD, '0, rand_key());
      for (i = 0; i < 8; i++)
         send_txn(bmhpq_pkg::FUNC_EXTRACT, '0, '0);
      wait_drained();
   endtask

   task automatic random_test(int target);
      int start;
      int n;
      int i;
      start = sent_count;
      while (sent_count - start < target) begin
         no_idle = ($urandom_range(0, 7) == 0);
         case ($urandom_range(0, 9))
            0: begin
               // noise: any operation with random fields
               send_txn(2'($urandom), bmhpq_pkg::VID_BITS'($urandom),
                        bmhpq_pkg::KEY_IN_BITS'($urandom));
            end
            1: begin
               // drain to empty and one more
               while (heap_count > 0)
                  send_txn(bmhpq_pkg::FUNC_EXTRACT, '0, '0);
               send_txn(bmhpq_pkg::FUNC_EXTRACT, bmhpq_pkg::VID_BITS'($urandom), '0);
            end
            default: begin
               // well-formed: loads, build, decreases, extracts
               n = $urandom_range(1, 20);
               for (i = 0; i < n && heap_count < 64; i++)
                  send_txn(bmhpq_pkg::FUNC_LOAD, bmhpq_pkg::VID_BITS'($urandom),
                           rand_key());
               if ($urandom_range(0, 3) != 0)
                  send_txn(bmhpq_pkg::FUNC_BUILD, bmhpq_pkg::VID_BITS'($urandom),
                           bmhpq_pkg::KEY_IN_BITS'($urandom));
               n = $urandom_range(0, 6);
               for (i = 0; i < n; i++)
                  send_txn(bmhpq_pkg::FUNC_DECREASE,
                           bmhpq_pkg::VID_BITS'($urandom_range(1, heap_count + 2)),
                           rand_key());
               n = $urandom_range(0, heap_count);
               for (i = 0; i < n; i++)
                  send_txn(bmhpq_pkg::FUNC_EXTRACT, bmhpq_pkg::VID_BITS'($urandom),
                           bmhpq_pkg::KEY_IN_BITS'($urandom));
            end
         endcase
      end
      no_idle = 1'b0;
      wait_drained();
   endtask

   initial begin
      error_count = 0;
      sent_count = 0;
      checked_count = 0;
      full_hits = 0;
      empty_hits = 0;
      missing_hits = 0;
      no_idle = 1'b0;
      long_hold = 0;
      rsp_stall = 0;
      busy_seen = 1'b0;
      heap_count = 0;
      reset = 1'b1;
      req_valid = 1'b0;
      req_data = '0;
      rsp_ready = 1'b0;
      repeat (4) @(posedge clock);
      reset <= 1'b0;
      @(posedge clock);

      empty_heap_test();
      directed_ops_test();
      back_pressure_test();
      random_test(460);

      req_valid <= 1'b0;
      wait (pending_rsp.size() == 0);
      repeat (TAIL_CYCLES) @(posedge clock);

      $display("covered %0d transactions, %0d responses checked", sent_count, checked_count);
      $display("full-heap loads %0d, empty extracts %0d, missing vertices %0d",
               full_hits, empty_hits, missing_hits);
      if (error_count == 0 && pending_rsp.size() == 0)
         $display("*** PASSED ***");
      else
         $display("*** FAILED ***");
      $finish;
   end

endmodule

`default_nettype wire
